// File: rtl/arc_pkg.sv
// Shared types, constants and helpers of the activity record correlator.
package arc_pkg;

  localparam int MAP_ENTRIES = 1024;
  localparam int MAP_AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int MAP_CW = $clog2(MAP_ENTRIES + 1);

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_NOTE    = 2'd1;
  localparam logic [1:0] CMD_RESOLVE = 2'd2;

  localparam logic [31:0] KIND_KERNEL  = 32'd10;
  localparam logic [31:0] KIND_MAPPING = 32'd39;
  localparam logic [15:0] MAPPING_MIN_BYTES = 16'd24;
  localparam logic [15:0] KERNEL_MIN_BYTES  = 16'd96;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_STORED   = 3'd1,
    ST_ZERO_ID  = 3'd2,
    ST_FULL     = 3'd3,
    ST_REJECTED = 3'd4,
    ST_UNMAPPED = 3'd5,
    ST_RESOLVED = 3'd6,
    ST_CLEARED  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] record_bytes;
    logic [31:0] record_kind;
    logic [63:0] word_at_8;
    logic [63:0] word_at_16;
    logic [63:0] word_at_24;
    logic [31:0] word_at_92;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] external_id;
    logic [63:0] start_ns;
    logic [63:0] end_ns;
    logic [31:0] correlation_id;
    logic [31:0] kernel_count;
    logic [31:0] rejected_count;
    logic [31:0] dropped_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] corr_id;
    logic [63:0] ext_id;
  } map_entry_t;

  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] addr;
    map_entry_t        data;
  } map_wr_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// File: rtl/activity_record_correlator_top.sv
// Top level of the activity record correlator: control, map memory, result register.
//
// Usage: activity records enter on the in_ channel (valid/ready), one beat per
// record, with a command: clear the map, note an external-correlation mapping,
// or resolve a concurrent-kernel record. Each beat yields exactly one result
// beat on the out_ channel (valid/ready) with status, ids, times and counters.
// Clear, note, ignored and rejected beats go from acceptance straight to the
// result. A good kernel beat walks the stored mappings through the single
// read port of the map memory, one entry per cycle, ending early at the first
// match.
// A new beat is taken once the previous result sits in the output register,
// so the next item starts while a result waits for the receiver. If the
// receiver stalls with a result still held, the finished result of the next
// item waits inside the block and in_ready stays low.
// Reset (rst_n low, synchronous) empties the map and zeroes all counters;
// the map memory itself is not cleared and needs no clearing pass.
module activity_record_correlator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  arc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output arc_pkg::out_item_t out_data
);

  arc_pkg::map_wr_t           map_wr;
  logic [arc_pkg::MAP_AW-1:0] map_rd_addr;
  arc_pkg::map_entry_t        map_rd_data;
  logic                       res_valid;
  logic                       res_ready;
  arc_pkg::out_item_t         res_data;
  logic                       out_valid_r, out_valid_nxt;
  arc_pkg::out_item_t         out_data_r, out_data_nxt;

  arc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .map_wr      (map_wr),
    .map_rd_addr (map_rd_addr),
    .map_rd_data (map_rd_data)
  );

  arc_map_ram u_map (
    .clk     (clk),
    .wr      (map_wr),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data)
  );

  // load a new result when the output register is empty or draining
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/arc_map_ram.sv
// Correlation map storage: one write port, one registered read port.
module arc_map_ram (
  input  logic                       clk,
  input  arc_pkg::map_wr_t           wr,
  input  logic [arc_pkg::MAP_AW-1:0] rd_addr,
  output arc_pkg::map_entry_t        rd_data
);

  arc_pkg::map_entry_t mem [arc_pkg::MAP_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/arc_ctrl.sv
// Command decode, counters and the map walk for kernel resolution.
module arc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  arc_pkg::in_item_t          in_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output arc_pkg::out_item_t         res_data,
  output arc_pkg::map_wr_t           map_wr,
  output logic [arc_pkg::MAP_AW-1:0] map_rd_addr,
  input  arc_pkg::map_entry_t        map_rd_data
);

  arc_pkg::state_t             state_r, state_nxt;
  logic [arc_pkg::MAP_CW-1:0]  used_r, used_nxt;
  logic [arc_pkg::MAP_CW-1:0]  idx_r, idx_nxt;
  logic                        chk_r, chk_nxt;
  logic [31:0]                 kern_r, kern_nxt;
  logic [31:0]                 rej_r, rej_nxt;
  logic [31:0]                 drop_r, drop_nxt;
  arc_pkg::out_item_t          res_r, res_nxt;
  logic                        in_fire;
  logic                        issue;
  logic                        hit;
  logic                        note_ok;
  logic                        kern_ok;
  logic                        bad_times;

  assign in_fire   = in_valid && in_ready;
  assign issue     = (state_r == arc_pkg::S_SCAN) && (idx_r < used_r);
  assign hit       = chk_r && (map_rd_data.corr_id == res_r.correlation_id);
  assign note_ok   = (in_data.record_kind == arc_pkg::KIND_MAPPING) &&
                     (in_data.record_bytes >= arc_pkg::MAPPING_MIN_BYTES);
  assign kern_ok   = (in_data.record_kind == arc_pkg::KIND_KERNEL) &&
                     (in_data.record_bytes >= arc_pkg::KERNEL_MIN_BYTES);
  assign bad_times = (in_data.word_at_16 == 64'd0) || (in_data.word_at_24 == 64'd0) ||
                     (in_data.word_at_24 < in_data.word_at_16);

  assign map_rd_addr = idx_r[arc_pkg::MAP_AW-1:0];

  always_comb begin
    res_data                = res_r;
    res_data.kernel_count   = kern_r;
    res_data.rejected_count = rej_r;
    res_data.dropped_count  = drop_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arc_pkg::S_IDLE;
      used_r  <= '0;
      chk_r   <= 1'b0;
      kern_r  <= '0;
      rej_r   <= '0;
      drop_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      chk_r   <= chk_nxt;
      kern_r  <= kern_nxt;
      rej_r   <= rej_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    idx_nxt   = idx_r;
    chk_nxt   = chk_r;
    kern_nxt  = kern_r;
    rej_nxt   = rej_r;
    drop_nxt  = drop_r;
    res_nxt   = res_r;
    map_wr    = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    case (state_r)
      arc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_nxt   = '0;
          res_nxt.status = arc_pkg::ST_IGNORED;
          state_nxt = arc_pkg::S_PUSH;
          case (in_data.cmd)
            arc_pkg::CMD_CLEAR: begin
              used_nxt       = '0;
              res_nxt.status = arc_pkg::ST_CLEARED;
            end
            arc_pkg::CMD_NOTE: begin
              if (note_ok) begin
                res_nxt.correlation_id = in_data.word_at_16[31:0];
                if (in_data.word_at_16[31:0] == 32'd0) begin
                  res_nxt.status = arc_pkg::ST_ZERO_ID;
                end else if (used_r >= arc_pkg::MAP_CW'(arc_pkg::MAP_ENTRIES)) begin
                  drop_nxt       = arc_pkg::sat_inc(drop_r);
                  res_nxt.status = arc_pkg::ST_FULL;
                end else begin
                  map_wr.we           = 1'b1;
                  map_wr.addr         = used_r[arc_pkg::MAP_AW-1:0];
                  map_wr.data.corr_id = in_data.word_at_16[31:0];
                  map_wr.data.ext_id  = in_data.word_at_8;
                  used_nxt            = used_r + arc_pkg::MAP_CW'(1);
                  res_nxt.status      = arc_pkg::ST_STORED;
                end
              end
            end
            arc_pkg::CMD_RESOLVE: begin
              if (kern_ok) begin
                if (bad_times) begin
                  rej_nxt        = arc_pkg::sat_inc(rej_r);
                  res_nxt.status = arc_pkg::ST_REJECTED;
                end else begin
                  kern_nxt               = arc_pkg::sat_inc(kern_r);
                  res_nxt.status         = arc_pkg::ST_UNMAPPED;
                  res_nxt.start_ns       = in_data.word_at_16;
                  res_nxt.end_ns         = in_data.word_at_24;
                  res_nxt.correlation_id = in_data.word_at_92;
                  idx_nxt                = '0;
                  chk_nxt                = 1'b0;
                  if (used_r != '0) begin
                    state_nxt = arc_pkg::S_SCAN;
                  end
                end
              end
            end
            default: begin
              res_nxt.status = arc_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      arc_pkg::S_SCAN: begin
        // one read issued per cycle, compared when its data returns
        if (hit) begin
          res_nxt.external_id = map_rd_data.ext_id;
          res_nxt.status      = arc_pkg::ST_RESOLVED;
          chk_nxt             = 1'b0;
          state_nxt           = arc_pkg::S_PUSH;
        end else if (!issue && !chk_r) begin
          state_nxt = arc_pkg::S_PUSH;
        end else begin
          if (issue) begin
            idx_nxt = idx_r + arc_pkg::MAP_CW'(1);
          end
          chk_nxt = issue;
        end
      end
      arc_pkg::S_PUSH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = arc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = arc_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    map_wr.we |-> in_fire && (in_data.cmd == arc_pkg::CMD_NOTE))
    else $error("map written outside a note beat");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= arc_pkg::MAP_CW'(arc_pkg::MAP_ENTRIES))
    else $error("map fill count beyond capacity");

  a_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arc_pkg::S_SCAN) && $past(state_r == arc_pkg::S_SCAN) |->
      $stable(used_r) && $stable(kern_r))
    else $error("state changed during map walk");

  a_kern_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> kern_r >= $past(kern_r))
    else $error("kernel counter went backward");

  a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.cmd != arc_pkg::CMD_RESOLVE) |=> state_r == arc_pkg::S_PUSH)
    else $error("non-resolve beat did not go straight to result");
`endif

endmodule

// File: bench/activity_record_correlator_top_test.sv
// Testbench for activity_record_correlator_top: mirrored map, directed and random records.
`timescale 1ns / 100ps

class correlation_mirror;
  logic [31:0]          entry_corr [arc_pkg::MAP_ENTRIES];
  logic [63:0]          entry_ext [arc_pkg::MAP_ENTRIES];
  int                   entry_count;
  logic [31:0]          kernel_total;
  logic [31:0]          refused_total;
  logic [31:0]          dropped_total;
  arc_pkg::out_item_t   pending_results [$];
  int                   failures;

  function new();
    entry_count   = 0;
    kernel_total  = '0;
    refused_total = '0;
    dropped_total = '0;
    failures      = 0;
  endfunction

  function logic [31:0] saturating_bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Work out the result of one accepted record and queue it.
  function arc_pkg::status_t note_record(arc_pkg::in_item_t rec);
    arc_pkg::out_item_t want;
    int                 k;
    want = '0;
    want.status = arc_pkg::ST_IGNORED;
    case (rec.cmd)
      arc_pkg::CMD_CLEAR: begin
        entry_count = 0;
        want.status = arc_pkg::ST_CLEARED;
      end
      arc_pkg::CMD_NOTE: begin
        if (rec.record_kind == arc_pkg::KIND_MAPPING &&
            rec.record_bytes >= arc_pkg::MAPPING_MIN_BYTES) begin
          want.correlation_id = rec.word_at_16[31:0];
          if (want.correlation_id == 32'd0) begin
            want.status = arc_pkg::ST_ZERO_ID;
          end else if (entry_count >= arc_pkg::MAP_ENTRIES) begin
            dropped_total = saturating_bump(dropped_total);
            want.status = arc_pkg::ST_FULL;
          end else begin
            entry_corr[entry_count] = want.correlation_id;
            entry_ext[entry_count]  = rec.word_at_8;
            entry_count++;
            want.status = arc_pkg::ST_STORED;
          end
        end
      end
      arc_pkg::CMD_RESOLVE: begin
        if (rec.record_kind == arc_pkg::KIND_KERNEL &&
            rec.record_bytes >= arc_pkg::KERNEL_MIN_BYTES) begin
          if (rec.word_at_16 == 64'd0 || rec.word_at_24 == 64'd0 ||
              rec.word_at_24 < rec.word_at_16) begin
            refused_total = saturating_bump(refused_total);
            want.status = arc_pkg::ST_REJECTED;
          end else begin
            kernel_total = saturating_bump(kernel_total);
            want.start_ns       = rec.word_at_16;
            want.end_ns         = rec.word_at_24;
            want.correlation_id = rec.word_at_92;
            want.status         = arc_pkg::ST_UNMAPPED;
            // first matching entry wins
            for (k = 0; k < entry_count; k++) begin
              if (entry_corr[k] == rec.word_at_92) begin
                want.external_id = entry_ext[k];
                want.status      = arc_pkg::ST_RESOLVED;
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    want.kernel_count   = kernel_total;
    want.rejected_count = refused_total;
    want.dropped_count  = dropped_total;
    pending_results.push_back(want);
    return want.status;
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  function void check_result(arc_pkg::out_item_t got);
    arc_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      failures++;
      $display("%0t: result beat with nothing expected, actual %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    check_field("status", 64'(want.status), 64'(got.status));
    check_field("external_id", want.external_id, got.external_id);
    check_field("start_ns", want.start_ns, got.start_ns);
    check_field("end_ns", want.end_ns, got.end_ns);
    check_field("correlation_id", 64'(want.correlation_id), 64'(got.correlation_id));
    check_field("kernel_count", 64'(want.kernel_count), 64'(got.kernel_count));
    check_field("rejected_count", 64'(want.rejected_count), 64'(got.rejected_count));
    check_field("dropped_count", 64'(want.dropped_count), 64'(got.dropped_count));
  endfunction

  function int pending();
    return pending_results.size();
  endfunction
endclass

module activity_record_correlator_top_test;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  arc_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  arc_pkg::out_item_t out_data;

  bit calm = 1'b0;
  int rx_cycle = 0;
  int hold_left = 0;

  correlation_mirror board = new();

  activity_record_correlator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic arc_pkg::in_item_t make_record(logic [1:0] cmd, logic [15:0] bytes,
                                                    logic [31:0] kind, logic [63:0] w8,
                                                    logic [63:0] w16, logic [63:0] w24,
                                                    logic [31:0] w92);
    arc_pkg::in_item_t rec;
    rec.cmd          = cmd;
    rec.record_bytes = bytes;
    rec.record_kind  = kind;
    rec.word_at_8    = w8;
    rec.word_at_16   = w16;
    rec.word_at_24   = w24;
    rec.word_at_92   = w92;
    return rec;
  endfunction

  function automatic arc_pkg::in_item_t random_record();
    arc_pkg::in_item_t rec;
    int                pick;
    bit                proper;
    logic [31:0]       corr;
    pick = $urandom_range(0, 99);
    if (pick < 6) rec.cmd = arc_pkg::CMD_CLEAR;
    else if (pick < 45) rec.cmd = arc_pkg::CMD_NOTE;
    else if (pick < 94) rec.cmd = arc_pkg::CMD_RESOLVE;
    else rec.cmd = CMD_UNUSED;
    proper = ($urandom_range(0, 99) < 85);
    rec.record_kind  = $urandom;
    rec.record_bytes = 16'($urandom_range(0, 65535));
    rec.word_at_8    = {$urandom, $urandom};
    rec.word_at_16   = {$urandom, $urandom};
    rec.word_at_24   = {$urandom, $urandom};
    rec.word_at_92   = $urandom;
    // small id pool so notes and kernels meet
    if ($urandom_range(0, 99) < 88) corr = 32'($urandom_range(1, 24));
    else if ($urandom_range(0, 3) == 0) corr = 32'd0;
    else corr = $urandom;
    case (rec.cmd)
      arc_pkg::CMD_NOTE: begin
        if (proper) begin
          rec.record_kind = arc_pkg::KIND_MAPPING;
          if ($urandom_range(0, 7) == 0) begin
            rec.record_bytes = arc_pkg::MAPPING_MIN_BYTES;
          end else begin
            rec.record_bytes = 16'($urandom_range(arc_pkg::MAPPING_MIN_BYTES, 65535));
          end
          rec.word_at_16[31:0] = corr;
        end else if ($urandom_range(0, 1) == 0) begin
          rec.record_kind  = arc_pkg::KIND_MAPPING;
          rec.record_bytes = 16'($urandom_range(0, arc_pkg::MAPPING_MIN_BYTES - 1));
        end
      end
      arc_pkg::CMD_RESOLVE: begin
        if (proper) begin
          rec.record_kind = arc_pkg::KIND_KERNEL;
          if ($urandom_range(0, 7) == 0) begin
            rec.record_bytes = arc_pkg::KERNEL_MIN_BYTES;
          end else begin
            rec.record_bytes = 16'($urandom_range(arc_pkg::KERNEL_MIN_BYTES, 65535));
          end
          rec.word_at_92 = corr;
          pick = $urandom_range(0, 9);
          if (pick < 8) begin
            rec.word_at_24 = rec.word_at_16 + 64'($urandom_range(0, 5000));
          end else if (pick == 8) begin
            if ($urandom_range(0, 1) == 0) rec.word_at_16 = 64'd0;
            else rec.word_at_24 = 64'd0;
          end
        end else if ($urandom_range(0, 1) == 0) begin
          rec.record_kind  = arc_pkg::KIND_KERNEL;
          rec.record_bytes = 16'($urandom_range(0, arc_pkg::KERNEL_MIN_BYTES - 1));
        end
      end
      default: ;
    endcase
    return rec;
  endfunction

  task automatic send_record(input arc_pkg::in_item_t rec, output arc_pkg::status_t st);
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    st = board.note_record(rec);
  endtask

  // Result side: check beats, stall at random, one set long hold-off, rare random ones.
  initial begin : result_side
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_result(out_data);
      rx_cycle++;
      if (rx_cycle == 3000 || (!calm && hold_left == 0 && $urandom_range(0, 1999) == 0))
        hold_left = $urandom_range(300, 500);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  initial begin : stimulus
    arc_pkg::status_t st;
    int               busy_items;
    int               k;
    logic [31:0]      tail_corr;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty map: kernel finds nothing
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd0, 64'd100, 64'd200, 32'd5), st);
    send_record(make_record(arc_pkg::CMD_NOTE, arc_pkg::MAPPING_MIN_BYTES,
                            arc_pkg::KIND_MAPPING, ALL_ONES, 64'd5, 64'd0, 32'd0), st);
    // zero id in the low half, junk above
    send_record(make_record(arc_pkg::CMD_NOTE, arc_pkg::MAPPING_MIN_BYTES,
                            arc_pkg::KIND_MAPPING, 64'd77, 64'hFFFF_FFFF_0000_0000,
                            64'd0, 32'd0), st);
    send_record(make_record(arc_pkg::CMD_NOTE, arc_pkg::MAPPING_MIN_BYTES - 16'd1,
                            arc_pkg::KIND_MAPPING, 64'd1, 64'd9, 64'd0, 32'd0), st);
    send_record(make_record(arc_pkg::CMD_NOTE, arc_pkg::MAPPING_MIN_BYTES,
                            arc_pkg::KIND_MAPPING - 32'd1, 64'd1, 64'd9, 64'd0, 32'd0), st);
    send_record(make_record(arc_pkg::CMD_NOTE, 16'hFFFF, 32'hFFFF_FFFF, ALL_ONES,
                            ALL_ONES, ALL_ONES, 32'hFFFF_FFFF), st);
    send_record(make_record(arc_pkg::CMD_NOTE, arc_pkg::MAPPING_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd1, 64'd9, 64'd0, 32'd0), st);
    // duplicate id: the first entry must win
    send_record(make_record(arc_pkg::CMD_NOTE, arc_pkg::MAPPING_MIN_BYTES,
                            arc_pkg::KIND_MAPPING, 64'd1, 64'd5, 64'd0, 32'd0), st);
    send_record(make_record(arc_pkg::CMD_NOTE, 16'hFFFF, arc_pkg::KIND_MAPPING,
                            64'h0123_4567_89AB_CDEF, ALL_ONES, ALL_ONES,
                            32'hFFFF_FFFF), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, ALL_ONES, 64'd1000, 64'd2000,
                            32'd5), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, 16'hFFFF, arc_pkg::KIND_KERNEL, 64'd0,
                            64'd1, ALL_ONES, 32'hFFFF_FFFF), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES - 16'd1,
                            arc_pkg::KIND_KERNEL, 64'd0, 64'd10, 64'd20, 32'd5), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_MAPPING, 64'd0, 64'd10, 64'd20, 32'd5), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd0, 64'd0, 64'd20, 32'd5), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd0, 64'd10, 64'd0, 32'd5), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd0, 64'd21, 64'd20, 32'd5), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd0, ALL_ONES, ALL_ONES, 32'd5), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd0, 64'd3, 64'd3, 32'd0), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, 16'hFFFF, 32'hFFFF_FFFF, ALL_ONES,
                            64'd3, 64'd4, 32'd5), st);
    send_record(make_record(CMD_UNUSED, arc_pkg::KERNEL_MIN_BYTES, arc_pkg::KIND_KERNEL,
                            64'd0, 64'd3, 64'd4, 32'd5), st);
    send_record(make_record(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, ALL_ONES,
                            ALL_ONES, ALL_ONES, 32'hFFFF_FFFF), st);
    send_record(make_record(arc_pkg::CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, ALL_ONES,
                            ALL_ONES, ALL_ONES, 32'hFFFF_FFFF), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd0, 64'd10, 64'd20, 32'd5), st);

    // Fill the map to the brim, overflow it, then walk it end to end.
    tail_corr = 32'd1;
    for (k = 0; k < arc_pkg::MAP_ENTRIES; k++) begin
      tail_corr = 32'($urandom_range(1, 4000));
      send_record(make_record(arc_pkg::CMD_NOTE,
                              16'($urandom_range(arc_pkg::MAPPING_MIN_BYTES, 65535)),
                              arc_pkg::KIND_MAPPING, {$urandom, $urandom},
                              {$urandom, tail_corr}, {$urandom, $urandom}, $urandom), st);
    end
    for (k = 0; k < 3; k++)
      send_record(make_record(arc_pkg::CMD_NOTE, arc_pkg::MAPPING_MIN_BYTES,
                              arc_pkg::KIND_MAPPING, {$urandom, $urandom},
                              64'(k + 1), 64'd0, 32'd0), st);
    send_record(make_record(arc_pkg::CMD_NOTE, arc_pkg::MAPPING_MIN_BYTES,
                            arc_pkg::KIND_MAPPING, 64'd1, 64'd0, 64'd0, 32'd0), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd0, 64'd50, 64'd60, tail_corr), st);
    for (k = 0; k < 4; k++)
      send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                              arc_pkg::KIND_KERNEL, 64'd0, 64'd50, 64'd60,
                              32'h8000_0000 | $urandom), st);
    send_record(make_record(arc_pkg::CMD_RESOLVE, arc_pkg::KERNEL_MIN_BYTES,
                            arc_pkg::KIND_KERNEL, 64'd0, 64'd50, 64'd60,
                            32'($urandom_range(1, 4000))), st);
    send_record(make_record(arc_pkg::CMD_CLEAR, 16'd0, 32'd0, 64'd0, 64'd0, 64'd0,
                            32'd0), st);

    busy_items = 0;
    while (busy_items < 580) begin
      calm = (busy_items >= 250 && busy_items < 350);
      send_record(random_record(), st);
      if (st != arc_pkg::ST_IGNORED) busy_items++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    // a stray extra beat would show up within one full scan
    repeat (1100) @(posedge clk);
    if (board.failures == 0) begin
      $display("activity_record_correlator_top regression: pass");
    end else begin
      $display("activity_record_correlator_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("activity_record_correlator_top regression: fail");
    $finish;
  end

endmodule

// File: activity_record_correlator_top.f
rtl/arc_pkg.sv
rtl/arc_map_ram.sv
rtl/arc_ctrl.sv
rtl/activity_record_correlator_top.sv
bench/activity_record_correlator_top_test.sv
